// File: sv/dbrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbrt_pkg
// shared constants, codes and types of the dirty block run tracker
// ---------------------------------------------------------------------------
package dbrt_pkg;

    localparam int NumBlocks  = 64;
    localparam int BlockBytes = 4096;
    localparam int MaxResults = 32;

    localparam int BlkW      = $clog2(NumBlocks);
    localparam int UsedW     = BlkW + 1;
    localparam int ByteShift = $clog2(BlockBytes);
    localparam int CntW      = $clog2(MaxResults + 1);

    localparam int ActW     = 2;
    localparam int OffW     = 18;
    localparam int LenW     = 19;
    localparam int EndW     = LenW + 1;
    localparam int CfgW     = 7;
    localparam int DataW    = 40;
    localparam int AddrW    = 3;
    localparam int RegIdxW  = AddrW - 2;
    localparam int ApbDataW = 32;

    localparam logic [CfgW-1:0]    BlockCountReset = CfgW'(NumBlocks);
    localparam logic [RegIdxW-1:0] RegBlockCount   = RegIdxW'(0);

    typedef enum logic [ActW-1:0] {
        ACT_MARK  = 2'd0,
        ACT_CLEAN = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic            clear_all;
        logic            range_en;
        logic            range_val;
        logic [BlkW-1:0] first_blk;
        logic [BlkW-1:0] last_blk;
        logic            bit_clr;
        logic [BlkW-1:0] bit_idx;
    } bm_ctrl_t;

    typedef struct packed {
        logic            found;
        logic [OffW-1:0] offset;
        logic [LenW-1:0] length;
        logic            last;
    } result_t;

endpackage
`default_nettype wire

// File: sv/dbrt_bitmap.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbrt_bitmap
// dirty flag per block with clear of all flags, range set/clear and single flag clear
// ---------------------------------------------------------------------------
module dbrt_bitmap
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  dbrt_pkg::bm_ctrl_t                ctrl,
    output logic [dbrt_pkg::NumBlocks-1:0]    dirty
);

    logic [dbrt_pkg::NumBlocks-1:0] dirty_reg;
    logic [dbrt_pkg::NumBlocks-1:0] dirty_next;

    always_comb
    begin
        dirty_next = dirty_reg;
        if (ctrl.clear_all)
        begin
            dirty_next = '0;
        end
        else
        begin
            if (ctrl.range_en)
            begin
                for (int k = 0; k < dbrt_pkg::NumBlocks; k++)
                begin
                    if ((dbrt_pkg::BlkW'(k) >= ctrl.first_blk) &&
                        (dbrt_pkg::BlkW'(k) <= ctrl.last_blk))
                    begin
                        dirty_next[k] = ctrl.range_val;
                    end
                end
            end
            if (ctrl.bit_clr)
            begin
                dirty_next[ctrl.bit_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg <= '0;
        end
        else
        begin
            dirty_reg <= dirty_next;
        end
    end

    assign dirty = dirty_reg;

endmodule
`default_nettype wire

// File: sv/dbrt_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbrt_seq
// request sequencer: range marking, block-by-block flush scan, result register
// ---------------------------------------------------------------------------
module dbrt_seq
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [dbrt_pkg::ActW-1:0]           in_action,
    input  wire  [dbrt_pkg::OffW-1:0]           in_offset,
    input  wire  [dbrt_pkg::LenW-1:0]           in_length,
    input  wire  [dbrt_pkg::UsedW-1:0]          used,
    input  wire  [dbrt_pkg::NumBlocks-1:0]      dirty,
    output dbrt_pkg::bm_ctrl_t                  ctrl,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output dbrt_pkg::result_t                   out_res
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MARK = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    dbrt_pkg::action_t             act_reg;
    logic [dbrt_pkg::OffW-1:0]     offset_reg;
    logic [dbrt_pkg::LenW-1:0]     length_reg;
    logic [dbrt_pkg::UsedW-1:0]    idx_reg, idx_next;
    logic                          in_run_reg, in_run_next;
    logic [dbrt_pkg::BlkW-1:0]     start_reg, start_next;
    logic [dbrt_pkg::CntW-1:0]     n_reg, n_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [dbrt_pkg::BlkW-1:0]     pend_start_reg, pend_start_next;
    logic [dbrt_pkg::UsedW-1:0]    pend_len_reg, pend_len_next;
    logic                          out_valid_reg, out_valid_next;
    dbrt_pkg::result_t             out_res_reg, out_res_next;

    logic                          accept;
    logic                          out_free;
    logic [dbrt_pkg::EndW-1:0]     end_sum;
    logic [dbrt_pkg::EndW-1:0]     end_blk;
    logic [dbrt_pkg::UsedW-1:0]    clip_blk;
    logic [dbrt_pkg::OffW-1:0]     first_full;
    logic                          range_ok;
    logic                          at_end;
    logic                          cur_bit;
    logic [dbrt_pkg::UsedW-1:0]    run_len;
    dbrt_pkg::result_t             pend_res;
    dbrt_pkg::result_t             ack_res;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // range end block, clipped to the blocks in use
    assign end_sum    = {1'b0, {(dbrt_pkg::LenW - dbrt_pkg::OffW){1'b0}}, offset_reg}
                        + {1'b0, length_reg};
    assign end_blk    = end_sum >> dbrt_pkg::ByteShift;
    assign first_full = offset_reg >> dbrt_pkg::ByteShift;
    assign clip_blk   = (end_blk >= dbrt_pkg::EndW'(used)) ?
                        (used - dbrt_pkg::UsedW'(1)) : dbrt_pkg::UsedW'(end_blk);
    assign range_ok   = (used != '0) &&
                        ((act_reg == dbrt_pkg::ACT_MARK) || (act_reg == dbrt_pkg::ACT_CLEAN)) &&
                        (first_full <= dbrt_pkg::OffW'(clip_blk));

    assign at_end  = (idx_reg == used);
    assign cur_bit = dirty[idx_reg[dbrt_pkg::BlkW-1:0]];
    assign run_len = idx_reg - {1'b0, start_reg};

    always_comb
    begin
        pend_res.found  = 1'b1;
        pend_res.offset = dbrt_pkg::OffW'(pend_start_reg) << dbrt_pkg::ByteShift;
        pend_res.length = dbrt_pkg::LenW'(pend_len_reg) << dbrt_pkg::ByteShift;
        pend_res.last   = 1'b0;
        ack_res.found   = 1'b0;
        ack_res.offset  = '0;
        ack_res.length  = '0;
        ack_res.last    = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        in_run_next     = in_run_reg;
        start_next      = start_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_res_next    = out_res_reg;
        ctrl            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    in_run_next     = 1'b0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    if (dbrt_pkg::action_t'(in_action) == dbrt_pkg::ACT_FLUSH)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                if (out_free)
                begin
                    ctrl.range_en  = range_ok;
                    ctrl.range_val = (act_reg == dbrt_pkg::ACT_MARK);
                    ctrl.first_blk = dbrt_pkg::BlkW'(first_full);
                    ctrl.last_blk  = clip_blk[dbrt_pkg::BlkW-1:0];
                    out_valid_next = 1'b1;
                    out_res_next   = ack_res;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                priority if (in_run_reg && !at_end && cur_bit)
                begin
                    ctrl.bit_clr = 1'b1;
                    ctrl.bit_idx = idx_reg[dbrt_pkg::BlkW-1:0];
                    idx_next     = idx_reg + dbrt_pkg::UsedW'(1);
                end
                else if (in_run_reg)
                begin
                    // run closed: older held run goes out, this one is held
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = pend_res;
                        end
                        pend_valid_next = 1'b1;
                        pend_start_next = start_reg;
                        pend_len_next   = run_len;
                        n_next          = n_reg + dbrt_pkg::CntW'(1);
                        in_run_next     = 1'b0;
                    end
                end
                else if (at_end || (n_reg == dbrt_pkg::CntW'(dbrt_pkg::MaxResults)))
                begin
                    state_next = ST_DONE;
                end
                else if (cur_bit)
                begin
                    in_run_next  = 1'b1;
                    start_next   = idx_reg[dbrt_pkg::BlkW-1:0];
                    ctrl.bit_clr = 1'b1;
                    ctrl.bit_idx = idx_reg[dbrt_pkg::BlkW-1:0];
                    idx_next     = idx_reg + dbrt_pkg::UsedW'(1);
                end
                else
                begin
                    idx_next = idx_reg + dbrt_pkg::UsedW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_res_next      = pend_res;
                        out_res_next.last = 1'b1;
                    end
                    else
                    begin
                        out_res_next = ack_res;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            in_run_reg     <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            in_run_reg     <= in_run_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= dbrt_pkg::action_t'(in_action);
            offset_reg <= in_offset;
            length_reg <= in_length;
        end
        start_reg      <= start_next;
        pend_start_reg <= pend_start_next;
        pend_len_reg   <= pend_len_next;
        out_res_reg    <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
`default_nettype wire

// File: sv/dirty_block_run_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dirty_block_run_tracker_unit
// dirty flag per store block, range mark/clean and flush of dirty runs
// ---------------------------------------------------------------------------
// One request is in work at a time. A mark, clean or unused request has the
// transfer, then, once the output register is free, the range write into the
// flag register (none for unused), which also loads the acknowledgment. A flush
// is stepped by one scan counter that visits one block per cycle while no run is
// closing; closing a run is a step of its own, held while an older run waits on
// the output register, and the scan stops after 32 runs. The last result of a
// request may sit in the output register while the next request is taken.
// Writing block_count clears all dirty flags; values above 64 act as 64.
module dirty_block_run_tracker_unit
(
    input  wire                                 clk,
    input  wire                                 rst_n,

    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [dbrt_pkg::AddrW-1:0]          paddr,
    input  wire  [dbrt_pkg::ApbDataW-1:0]       pwdata,
    output logic [dbrt_pkg::ApbDataW-1:0]       prdata,
    output logic                                pready,

    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [dbrt_pkg::DataW-1:0]          s_axis_tdata,   // byte_offset, byte_length
    input  wire  [dbrt_pkg::ActW-1:0]           s_axis_tuser,   // action

    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [dbrt_pkg::DataW-1:0]          m_axis_tdata,   // run_offset, run_length
    output logic                                m_axis_tuser,   // run_found
    output logic                                m_axis_tlast
);

    logic [dbrt_pkg::CfgW-1:0]      block_count_reg, block_count_next;
    logic [dbrt_pkg::RegIdxW-1:0]   reg_idx;
    logic                           cfg_wr;
    logic [dbrt_pkg::UsedW-1:0]     used;
    logic [dbrt_pkg::NumBlocks-1:0] dirty;
    dbrt_pkg::bm_ctrl_t             seq_ctrl;
    dbrt_pkg::bm_ctrl_t             bm_ctrl;
    dbrt_pkg::result_t              res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[dbrt_pkg::AddrW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready &&
                     (reg_idx == dbrt_pkg::RegBlockCount);
    assign prdata  = (reg_idx == dbrt_pkg::RegBlockCount) ?
                     dbrt_pkg::ApbDataW'(block_count_reg) : '0;

    assign block_count_next = cfg_wr ? pwdata[dbrt_pkg::CfgW-1:0] : block_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= dbrt_pkg::BlockCountReset;
        end
        else
        begin
            block_count_reg <= block_count_next;
        end
    end

    assign used = (block_count_reg > dbrt_pkg::CfgW'(dbrt_pkg::NumBlocks)) ?
                  dbrt_pkg::UsedW'(dbrt_pkg::NumBlocks) : dbrt_pkg::UsedW'(block_count_reg);

    always_comb
    begin
        bm_ctrl           = seq_ctrl;
        bm_ctrl.clear_all = cfg_wr;
    end

    dbrt_bitmap u_bitmap
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (bm_ctrl),
        .dirty (dirty)
    );

    dbrt_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_offset (s_axis_tdata[dbrt_pkg::OffW-1:0]),
        .in_length (s_axis_tdata[dbrt_pkg::OffW+dbrt_pkg::LenW-1:dbrt_pkg::OffW]),
        .used      (used),
        .dirty     (dirty),
        .ctrl      (seq_ctrl),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = dbrt_pkg::DataW'({res.length, res.offset});
    assign m_axis_tuser = res.found;
    assign m_axis_tlast = res.last;

    // a block count write leaves every flag clean
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (dirty == '0))
        else $error("dirty flags survive a block count write");

    // acknowledgments always close their request
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("acknowledgment without last");

    // a reported run covers at least one block
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[dbrt_pkg::OffW+dbrt_pkg::LenW-1:dbrt_pkg::OffW] != '0))
        else $error("dirty run of zero length");

endmodule
`default_nettype wire
